/* src/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge, ignored while in reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/tgpts_pkg.sv */
// ----------------------------------------------------------------------------
// tgpts_pkg
// Shared types, codes and constants of the two-group task scheduler.
// ----------------------------------------------------------------------------
package tgpts_pkg;

   localparam int NUM_SLOTS_DEF = 64;
   localparam int ID_W          = 10;
   localparam int CMD_W         = 2;
   localparam int CLASS_W       = 2;
   localparam int LIST_W        = 4;
   localparam int NUM_LISTS     = 9;

   // run lists are 4 * group + class, then the wait list
   localparam logic [LIST_W-1:0] LIST_FIRST_RUN = 4'd0;
   localparam logic [LIST_W-1:0] LIST_LAST_RUN  = 4'd7;
   localparam logic [LIST_W-1:0] LIST_WAIT      = 4'd8;

   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SCHED = 2'd1;
   localparam logic [CMD_W-1:0] CMD_START = 2'd2;
   localparam logic [CMD_W-1:0] CMD_STOP  = 2'd3;

   localparam logic [1:0] MODE_QUEUED = 2'd1;
   localparam logic [1:0] MODE_WAIT   = 2'd2;
   localparam logic [1:0] MODE_RUN    = 2'd3;

   localparam logic [CLASS_W-1:0] CLASS_LAST = 2'd3;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_ALLOC,
      OP_LOAD_R,
      OP_SCHED_FLAGS,
      OP_PICK_FIRST,
      OP_NEXT_CLASS,
      OP_FIND_WAIT,
      OP_LIST_FIRST,
      OP_NEXT_LIST,
      OP_STEP,
      OP_UNLINK,
      OP_SETL_RES,
      OP_SETL_WAIT,
      OP_STOP_R,
      OP_PUSH1,
      OP_PUSH2,
      OP_SWAP,
      OP_SCHED_DONE,
      OP_SCHED_IDLE,
      OP_SET_FAIL,
      OP_RESP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             s_nil;
      logic             match;
      logic             r_zero;
      logic [1:0]       rd_mode;
      logic             free_empty;
      logic             ran;
      logic             last_class;
      logic             last_list;
      logic             rsp_stall;
   } dp_stat_type;

endpackage

/* src/tgpts_ctrl.sv */
// ----------------------------------------------------------------------------
// tgpts_ctrl
// Command sequencer: steps the datapath through list walks and updates.
// ----------------------------------------------------------------------------
module tgpts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tgpts_pkg::dp_stat_type  stat,
   output tgpts_pkg::dp_cmd_type   cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_PUSH1,
      ST_PUSH2,
      ST_SC_FLAGS,
      ST_PICK_FIRST,
      ST_PICK_CHECK,
      ST_SC_DONE,
      ST_WALK_START,
      ST_START_L,
      ST_STOP_R,
      ST_SEARCH_INIT,
      ST_SEARCH,
      ST_STOP_L,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd.op   = tgpts_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = tgpts_pkg::OP_ACCEPT;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (stat.cmd)
               tgpts_pkg::CMD_ADD: begin
                  if (stat.free_empty) begin
                     cmd.op   = tgpts_pkg::OP_SET_FAIL;
                     state_in = ST_DONE;
                  end else begin
                     cmd.op   = tgpts_pkg::OP_ALLOC;
                     state_in = ST_PUSH1;
                     ret_in   = ST_DONE;
                  end
               end
               tgpts_pkg::CMD_SCHED: begin
                  cmd.op   = tgpts_pkg::OP_LOAD_R;
                  state_in = ST_SC_FLAGS;
               end
               tgpts_pkg::CMD_START: begin
                  cmd.op   = tgpts_pkg::OP_FIND_WAIT;
                  state_in = ST_WALK_START;
               end
               default: begin
                  cmd.op   = tgpts_pkg::OP_LOAD_R;
                  state_in = ST_STOP_R;
               end
            endcase
         end
         ST_PUSH1: begin
            cmd.op   = tgpts_pkg::OP_PUSH1;
            state_in = ST_PUSH2;
         end
         ST_PUSH2: begin
            cmd.op   = tgpts_pkg::OP_PUSH2;
            state_in = ret_ff;
         end
         ST_SC_FLAGS: begin
            cmd.op = tgpts_pkg::OP_SCHED_FLAGS;
            if (!stat.r_zero && stat.rd_mode == tgpts_pkg::MODE_RUN) begin
               state_in = ST_PUSH1;
               ret_in   = ST_PICK_FIRST;
            end else begin
               state_in = ST_PICK_FIRST;
            end
         end
         ST_PICK_FIRST: begin
            cmd.op   = tgpts_pkg::OP_PICK_FIRST;
            state_in = ST_PICK_CHECK;
         end
         ST_PICK_CHECK: begin
            priority if (!stat.s_nil) begin
               cmd.op   = tgpts_pkg::OP_UNLINK;
               state_in = ST_SC_DONE;
            end else if (!stat.last_class) begin
               cmd.op = tgpts_pkg::OP_NEXT_CLASS;
            end else if (stat.ran) begin
               cmd.op   = tgpts_pkg::OP_SWAP;
               state_in = ST_PICK_FIRST;
            end else begin
               cmd.op   = tgpts_pkg::OP_SCHED_IDLE;
               state_in = ST_DONE;
            end
         end
         ST_SC_DONE: begin
            cmd.op   = tgpts_pkg::OP_SCHED_DONE;
            state_in = ST_DONE;
         end
         ST_WALK_START: begin
            priority if (stat.s_nil) begin
               cmd.op   = tgpts_pkg::OP_SET_FAIL;
               state_in = ST_DONE;
            end else if (stat.match) begin
               cmd.op   = tgpts_pkg::OP_UNLINK;
               state_in = ST_START_L;
            end else begin
               cmd.op = tgpts_pkg::OP_STEP;
            end
         end
         ST_START_L: begin
            cmd.op   = tgpts_pkg::OP_SETL_RES;
            state_in = ST_PUSH1;
            ret_in   = ST_DONE;
         end
         ST_STOP_R: begin
            cmd.op = tgpts_pkg::OP_STOP_R;
            if (!stat.r_zero && stat.match && stat.rd_mode == tgpts_pkg::MODE_RUN) begin
               state_in = ST_PUSH1;
               ret_in   = ST_SEARCH_INIT;
            end else begin
               state_in = ST_SEARCH_INIT;
            end
         end
         ST_SEARCH_INIT: begin
            cmd.op   = tgpts_pkg::OP_LIST_FIRST;
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            priority if (stat.s_nil) begin
               if (stat.last_list) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.op = tgpts_pkg::OP_NEXT_LIST;
               end
            end else if (stat.match) begin
               cmd.op   = tgpts_pkg::OP_UNLINK;
               state_in = ST_STOP_L;
            end else begin
               cmd.op = tgpts_pkg::OP_STEP;
            end
         end
         ST_STOP_L: begin
            cmd.op   = tgpts_pkg::OP_SETL_WAIT;
            state_in = ST_PUSH1;
            ret_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!stat.rsp_stall) begin
               cmd.op   = tgpts_pkg::OP_RESP;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_DONE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

/* src/tgpts_dp.sv */
// ----------------------------------------------------------------------------
// tgpts_dp
// Slot memories, list heads and tails, scheduler registers and result stage.
// ----------------------------------------------------------------------------
module tgpts_dp #(
   parameter int NUM_SLOTS = tgpts_pkg::NUM_SLOTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tgpts_pkg::dp_cmd_type               cmd,
   output tgpts_pkg::dp_stat_type              stat,
   input  logic [tgpts_pkg::CMD_W-1:0]         req_cmd,
   input  logic [tgpts_pkg::ID_W-1:0]          req_task_id,
   input  logic [tgpts_pkg::CLASS_W-1:0]       req_task_class,
   input  logic                                csr_we,
   input  logic [tgpts_pkg::ID_W-1:0]          csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_status,
   output logic [tgpts_pkg::ID_W-1:0]          rsp_running_task_id,
   output logic                                rsp_switched
);

   localparam int AW = $clog2(NUM_SLOTS);
   localparam int PW = $clog2(NUM_SLOTS + 1);
   localparam logic [PW-1:0] NIL = PW'(NUM_SLOTS);

   // slot memories
   logic [tgpts_pkg::ID_W-1:0]    task_mem  [NUM_SLOTS];
   logic [tgpts_pkg::CLASS_W-1:0] class_mem [NUM_SLOTS];
   logic [1:0]                    mode_mem  [NUM_SLOTS];
   logic [PW-1:0]                 next_mem  [NUM_SLOTS];
   logic [PW-1:0]                 prev_mem  [NUM_SLOTS];

   logic [tgpts_pkg::ID_W-1:0]    rd_task_ff;
   logic [tgpts_pkg::CLASS_W-1:0] rd_class_ff;
   logic [1:0]                    rd_mode_ff;
   logic [PW-1:0]                 rd_next_ff, rd_prev_ff;

   logic [PW-1:0] head_ff [tgpts_pkg::NUM_LISTS];
   logic [PW-1:0] tail_ff [tgpts_pkg::NUM_LISTS];

   logic [PW-1:0]                 s_ff, s_in;
   logic [tgpts_pkg::LIST_W-1:0]  l_ff, l_in;
   logic [PW-1:0]                 free_ff, running_ff;
   logic                          ag_ff, ag_in, ran_ff, ran_in;
   logic [tgpts_pkg::ID_W-1:0]    idle_id_ff, prev_id_ff, run_id_ff;
   logic [tgpts_pkg::CMD_W-1:0]   cmd_ff;
   logic [tgpts_pkg::ID_W-1:0]    id_ff;
   logic [tgpts_pkg::CLASS_W-1:0] cls_ff;
   logic                          status_ff, found_ff, switched_ff;
   logic                          rsp_valid_ff, rsp_status_ff, rsp_switched_ff;
   logic [tgpts_pkg::ID_W-1:0]    rsp_id_ff;

   logic [PW-1:0] hd, tl;
   logic          r_zero, match;

   logic                          next_we, prev_we, mode_we, slot_we;
   logic [PW-1:0]                 next_wa, prev_wa, next_wd, prev_wd;
   logic [AW-1:0]                 mode_wa;
   logic [1:0]                    mode_wd;

   assign hd     = head_ff[l_in];
   assign tl     = tail_ff[l_in];
   assign r_zero = (running_ff == '0);
   assign match  = (rd_task_ff == id_ff);

   always_comb begin
      s_in    = s_ff;
      l_in    = l_ff;
      ag_in   = ag_ff;
      ran_in  = ran_ff;
      next_we = 1'b0;
      next_wa = s_ff;
      next_wd = hd;
      prev_we = 1'b0;
      prev_wa = s_ff;
      prev_wd = NIL;
      mode_we = 1'b0;
      mode_wa = s_ff[AW-1:0];
      mode_wd = tgpts_pkg::MODE_RUN;
      slot_we = 1'b0;
      unique case (cmd.op)
         tgpts_pkg::OP_ALLOC: begin
            s_in    = free_ff;
            l_in    = {1'b0, ~ag_ff, cls_ff};
            slot_we = 1'b1;
         end
         tgpts_pkg::OP_LOAD_R: s_in = running_ff;
         tgpts_pkg::OP_SCHED_FLAGS: begin
            l_in = {1'b0, ~ag_ff, rd_class_ff};
            if (r_zero) begin
               ag_in  = ~ag_ff;
               ran_in = 1'b0;
            end else begin
               ran_in = (rd_mode_ff == tgpts_pkg::MODE_RUN) ||
                        (rd_mode_ff == tgpts_pkg::MODE_QUEUED);
            end
         end
         tgpts_pkg::OP_PICK_FIRST: begin
            l_in = {1'b0, ag_ff, 2'b00};
            s_in = tl;
         end
         tgpts_pkg::OP_NEXT_CLASS: begin
            l_in = l_ff + 1'b1;
            s_in = tl;
         end
         tgpts_pkg::OP_FIND_WAIT: begin
            l_in = tgpts_pkg::LIST_WAIT;
            s_in = hd;
         end
         tgpts_pkg::OP_LIST_FIRST: begin
            l_in = tgpts_pkg::LIST_FIRST_RUN;
            s_in = hd;
         end
         tgpts_pkg::OP_NEXT_LIST: begin
            l_in = l_ff + 1'b1;
            s_in = hd;
         end
         tgpts_pkg::OP_STEP: s_in = rd_next_ff;
         tgpts_pkg::OP_UNLINK: begin
            // bridge the neighbours around the slot
            next_we = (rd_prev_ff != NIL);
            next_wa = rd_prev_ff;
            next_wd = rd_next_ff;
            prev_we = (rd_next_ff != NIL);
            prev_wa = rd_next_ff;
            prev_wd = rd_prev_ff;
         end
         tgpts_pkg::OP_SETL_RES:  l_in = {1'b0, ~ag_ff, rd_class_ff};
         tgpts_pkg::OP_SETL_WAIT: l_in = tgpts_pkg::LIST_WAIT;
         tgpts_pkg::OP_STOP_R:    l_in = tgpts_pkg::LIST_WAIT;
         tgpts_pkg::OP_PUSH1: begin
            next_we = 1'b1;
            prev_we = 1'b1;
            mode_we = 1'b1;
            mode_wd = (l_ff == tgpts_pkg::LIST_WAIT) ? tgpts_pkg::MODE_WAIT
                                                     : tgpts_pkg::MODE_QUEUED;
         end
         tgpts_pkg::OP_PUSH2: begin
            prev_we = (hd != NIL);
            prev_wa = hd;
            prev_wd = s_ff;
         end
         tgpts_pkg::OP_SWAP: begin
            ag_in  = ~ag_ff;
            ran_in = 1'b0;
         end
         tgpts_pkg::OP_SCHED_DONE: mode_we = 1'b1;
         default: ;
      endcase
   end

   // memories: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (slot_we) begin
         task_mem[s_in[AW-1:0]]  <= id_ff;
         class_mem[s_in[AW-1:0]] <= cls_ff;
      end
      if (next_we) next_mem[next_wa[AW-1:0]] <= next_wd;
      if (prev_we) prev_mem[prev_wa[AW-1:0]] <= prev_wd;
      if (mode_we) mode_mem[mode_wa] <= mode_wd;
      rd_task_ff  <= task_mem[s_in[AW-1:0]];
      rd_class_ff <= class_mem[s_in[AW-1:0]];
      rd_mode_ff  <= mode_mem[s_in[AW-1:0]];
      rd_next_ff  <= next_mem[s_in[AW-1:0]];
      rd_prev_ff  <= prev_mem[s_in[AW-1:0]];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tgpts_pkg::NUM_LISTS; i++) begin
            head_ff[i] <= NIL;
            tail_ff[i] <= NIL;
         end
         free_ff      <= PW'(1);
         running_ff   <= '0;
         ag_ff        <= 1'b0;
         ran_ff       <= 1'b0;
         idle_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ag_ff  <= ag_in;
         ran_ff <= ran_in;
         if (csr_we) idle_id_ff <= csr_wdata;
         if (cmd.op == tgpts_pkg::OP_ALLOC) free_ff <= free_ff + 1'b1;
         if (cmd.op == tgpts_pkg::OP_UNLINK) begin
            if (rd_prev_ff == NIL) head_ff[l_ff] <= rd_next_ff;
            if (rd_next_ff == NIL) tail_ff[l_ff] <= rd_prev_ff;
         end
         if (cmd.op == tgpts_pkg::OP_PUSH1 && tl == NIL) tail_ff[l_ff] <= s_ff;
         if (cmd.op == tgpts_pkg::OP_PUSH2) head_ff[l_ff] <= s_ff;
         if (cmd.op == tgpts_pkg::OP_SCHED_DONE) running_ff <= s_ff;
         if (cmd.op == tgpts_pkg::OP_SCHED_IDLE) running_ff <= '0;
         if (cmd.op == tgpts_pkg::OP_RESP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s_ff <= s_in;
      l_ff <= l_in;
      unique case (cmd.op)
         tgpts_pkg::OP_ACCEPT: begin
            cmd_ff      <= req_cmd;
            id_ff       <= req_task_id;
            cls_ff      <= req_task_class;
            status_ff   <= 1'b0;
            found_ff    <= 1'b0;
            switched_ff <= 1'b0;
         end
         tgpts_pkg::OP_SCHED_FLAGS: prev_id_ff <= r_zero ? idle_id_ff : rd_task_ff;
         tgpts_pkg::OP_STOP_R: found_ff <= !r_zero && match &&
                                  ((rd_mode_ff == tgpts_pkg::MODE_RUN) ||
                                   (rd_mode_ff == tgpts_pkg::MODE_WAIT));
         tgpts_pkg::OP_SETL_WAIT: found_ff <= 1'b1;
         tgpts_pkg::OP_SET_FAIL:  status_ff <= 1'b1;
         tgpts_pkg::OP_SCHED_DONE: begin
            run_id_ff   <= rd_task_ff;
            switched_ff <= (rd_task_ff != prev_id_ff);
         end
         tgpts_pkg::OP_SCHED_IDLE: switched_ff <= (idle_id_ff != prev_id_ff);
         tgpts_pkg::OP_RESP: begin
            rsp_status_ff   <= status_ff ||
                               (cmd_ff == tgpts_pkg::CMD_STOP && !found_ff);
            rsp_id_ff       <= r_zero ? idle_id_ff : run_id_ff;
            rsp_switched_ff <= switched_ff;
         end
         default: ;
      endcase
   end

   assign stat.cmd        = cmd_ff;
   assign stat.s_nil      = (s_ff == NIL);
   assign stat.match      = match;
   assign stat.r_zero     = r_zero;
   assign stat.rd_mode    = rd_mode_ff;
   assign stat.free_empty = (free_ff == NIL);
   assign stat.ran        = ran_ff;
   assign stat.last_class = (l_ff[tgpts_pkg::CLASS_W-1:0] == tgpts_pkg::CLASS_LAST);
   assign stat.last_list  = (l_ff == tgpts_pkg::LIST_LAST_RUN);
   assign stat.rsp_stall  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_running_task_id = rsp_id_ff;
   assign rsp_switched        = rsp_switched_ff;

endmodule

/* src/two_group_priority_task_scheduler.sv */
// ----------------------------------------------------------------------------
// two_group_priority_task_scheduler
// Task scheduler with a slot pool, active and reserved run groups of four
// class queues each, and a wait list.
//
//   channel   ports                               direction
//   req       req_valid/ready, cmd, id, class     in
//   rsp       rsp_valid/ready, status, id, swtch  out
//   csr       csr_we, csr_wdata (idle task id)    in
//
// each command runs as a sequence of datapath operations;
// start and stop walk the wait list or the run lists node by node through
// the registered read port of the slot memories, schedule scans up to eight
// class queues. a new command is taken once the previous one has finished,
// even while its result still waits in the output register. no clearing pass
// after reset: the free pool is a fill counter.
// ----------------------------------------------------------------------------
module two_group_priority_task_scheduler #(
   parameter int NUM_SLOTS = tgpts_pkg::NUM_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // command transfer
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tgpts_pkg::CMD_W-1:0]    req_cmd,
   input  logic [tgpts_pkg::ID_W-1:0]     req_task_id,
   input  logic [tgpts_pkg::CLASS_W-1:0]  req_task_class,
   // result transfer
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_status,
   output logic [tgpts_pkg::ID_W-1:0]     rsp_running_task_id,
   output logic                           rsp_switched,
   // idle task id register
   input  logic                           csr_we,
   input  logic [tgpts_pkg::ID_W-1:0]     csr_wdata
);

   tgpts_pkg::dp_cmd_type  cmd;
   tgpts_pkg::dp_stat_type stat;

   // sequencer: one datapath operation per cycle
   tgpts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // slot memories, list pointers and the result register
   tgpts_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_cmd             (req_cmd),
      .req_task_id         (req_task_id),
      .req_task_class      (req_task_class),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_running_task_id (rsp_running_task_id),
      .rsp_switched        (rsp_switched)
   );

endmodule

/* src/tgpts_checker.sv */
// ----------------------------------------------------------------------------
// tgpts_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tgpts_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_status,
   input logic [tgpts_pkg::ID_W-1:0]     rsp_running_task_id,
   input logic                           rsp_switched
);

   // a waiting result stays offered with its payload held
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_running_task_id) && $stable(rsp_switched), "result dropped or changed")
   `ASSERT_CLK(a_busy_after_take, clock, reset, req_valid && req_ready |=> !req_ready, "took two commands")
   `ASSERT_CLK(a_fail_no_switch, clock, reset, rsp_valid && rsp_status |-> !rsp_switched, "fail with switch")
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result after reset")

endmodule

bind two_group_priority_task_scheduler tgpts_checker u_tgpts_checker (.*);

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-group task scheduler: a behavioural
// scheduler model predicts every result, which is compared field by field.
// ----------------------------------------------------------------------------
module tb;

   localparam int NS  = tgpts_pkg::NUM_SLOTS_DEF;
   localparam int NIL = NS;
   localparam int IW  = tgpts_pkg::ID_W;
   localparam int CW  = tgpts_pkg::CMD_W;
   localparam int KW  = tgpts_pkg::CLASS_W;

   // model list numbering: 0 free, 1 + 4*group + class run queues, 9 wait
   localparam int L_FREE = 0;
   localparam int L_WAIT = 9;
   localparam int NL     = 10;

   localparam logic [1:0] M_FREE = 2'd0;

   typedef struct packed {
      logic           status;
      logic [IW-1:0]  run_id;
      logic           switched;
   } sched_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [CW-1:0]    req_cmd = tgpts_pkg::CMD_ADD;
   logic [IW-1:0]    req_task_id = '0;
   logic [KW-1:0]    req_task_class = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_status;
   logic [IW-1:0]    rsp_running_task_id;
   logic             rsp_switched;
   logic             csr_we = 1'b0;
   logic [IW-1:0]    csr_wdata = '0;

   two_group_priority_task_scheduler DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_task_id(req_task_id), .req_task_class(req_task_class),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_running_task_id(rsp_running_task_id), .rsp_switched(rsp_switched),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // --------------------------------------------------------------------
   // scheduler model state
   // --------------------------------------------------------------------
   logic [IW-1:0]    idle_id;
   logic [IW-1:0]    m_task  [NS];
   logic [KW-1:0]    m_class [NS];
   logic [1:0]       m_mode  [NS];
   int               m_next  [NS];
   int               m_head  [NL];
   int               m_tail  [NL];
   int               cur_slot;
   bit               act_grp;
   bit               ran;

   sched_result_type expected_q[$];
   int  mismatches = 0;
   bit  rsp_noidle = 0;      // long stretch with the receiver always ready
   bit  req_noidle = 0;
   int  hold_off   = 0;      // cycles for which the receiver refuses transfers
   int  ids_used[$];         // ids handed out by add, to aim start/stop at them

   function automatic logic [IW-1:0] id_of(int s);
      return (s == 0) ? idle_id : m_task[s];
   endfunction

   function automatic void push_front(int l, int s);
      m_next[s] = m_head[l];
      m_head[l] = s;
      if (m_tail[l] == NIL) m_tail[l] = s;
   endfunction

   function automatic void unlink(int l, int s);
      int prev, cur;
      prev = NIL;
      cur  = m_head[l];
      while (cur != NIL) begin
         if (cur == s) begin
            if (prev == NIL) m_head[l] = m_next[s];
            else m_next[prev] = m_next[s];
            if (m_tail[l] == s) m_tail[l] = prev;
            return;
         end
         prev = cur;
         cur  = m_next[cur];
      end
   endfunction

   function automatic int pop_oldest(int l);
      int s;
      s = m_tail[l];
      if (s != NIL) unlink(l, s);
      return s;
   endfunction

   function automatic int find_id(int l, logic [IW-1:0] id);
      int cur;
      cur = m_head[l];
      while (cur != NIL) begin
         if (m_task[cur] == id) return cur;
         cur = m_next[cur];
      end
      return NIL;
   endfunction

   function automatic void queue_reserved(int s);
      push_front(1 + 4 * int'(!act_grp) + int'(m_class[s]), s);
      m_mode[s] = tgpts_pkg::MODE_QUEUED;
   endfunction

   function automatic int pick_active();
      int s;
      for (int c = 0; c < 4; c++) begin
         s = pop_oldest(1 + 4 * int'(act_grp) + c);
         if (s != NIL) return s;
      end
      return NIL;
   endfunction

   function automatic void sched_reset();
      idle_id = '0;
      for (int s = 0; s < NS; s++) begin
         m_task[s] = '0; m_class[s] = '0; m_mode[s] = M_FREE; m_next[s] = NIL;
      end
      for (int l = 0; l < NL; l++) begin
         m_head[l] = NIL; m_tail[l] = NIL;
      end
      m_mode[0] = tgpts_pkg::MODE_RUN;
      for (int s = 1; s < NS; s++) push_front(L_FREE, s);
      cur_slot = 0; act_grp = 0; ran = 0;
   endfunction

   function automatic sched_result_type sched_predict(logic [CW-1:0] cmd,
                                                      logic [IW-1:0] id,
                                                      logic [KW-1:0] cls);
      sched_result_type res;
      int s, r;
      logic [IW-1:0] prev_id;
      bit found;
      bit hit;
      res = '0;
      r = cur_slot;
      case (cmd)
         tgpts_pkg::CMD_ADD: begin
            s = pop_oldest(L_FREE);
            if (s == NIL) res.status = 1'b1;
            else begin
               m_task[s] = id; m_class[s] = cls;
               queue_reserved(s);
            end
         end
         tgpts_pkg::CMD_SCHED: begin
            prev_id = id_of(r);
            if (r == 0) begin
               act_grp = !act_grp; ran = 0;
            end else if (m_mode[r] == tgpts_pkg::MODE_RUN) begin
               queue_reserved(r); ran = 1;
            end else if (m_mode[r] == tgpts_pkg::MODE_QUEUED) ran = 1;
            else ran = 0;
            s = pick_active();
            if (s == NIL && ran) begin
               act_grp = !act_grp; ran = 0;
               s = pick_active();
            end
            if (s == NIL) s = 0;
            if (s != 0) m_mode[s] = tgpts_pkg::MODE_RUN;
            cur_slot = s;
            r = s;
            res.switched = (id_of(s) != prev_id);
         end
         tgpts_pkg::CMD_START: begin
            s = find_id(L_WAIT, id);
            if (s == NIL) res.status = 1'b1;
            else begin
               unlink(L_WAIT, s);
               queue_reserved(s);
            end
         end
         default: begin
            found = 0;
            if (r != 0 && m_task[r] == id) begin
               if (m_mode[r] == tgpts_pkg::MODE_RUN) begin
                  push_front(L_WAIT, r); m_mode[r] = tgpts_pkg::MODE_WAIT; found = 1;
               end else if (m_mode[r] == tgpts_pkg::MODE_WAIT) found = 1;
            end
            // first queued match, group 0 then 1, kernel to user
            hit = 0;
            for (int l = 1; l <= 8 && !hit; l++) begin
               s = find_id(l, id);
               if (s != NIL) begin
                  unlink(l, s); push_front(L_WAIT, s);
                  m_mode[s] = tgpts_pkg::MODE_WAIT; found = 1; hit = 1;
               end
            end
            res.status = !found;
         end
      endcase
      res.run_id = id_of(r);
      return res;
   endfunction

   // --------------------------------------------------------------------
   // stimulus helpers
   // --------------------------------------------------------------------
   task automatic send_cmd(logic [CW-1:0] cmd, logic [IW-1:0] id,
                           logic [KW-1:0] cls);
      // random gap before the transfer
      while (!req_noidle && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_task_id    <= id;
      req_task_class <= cls;
      do @(posedge clock); while (!req_ready);
      expected_q.push_back(sched_predict(cmd, id, cls));
      if (cmd == tgpts_pkg::CMD_ADD) ids_used.push_back(id);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_idle_id(logic [IW-1:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      idle_id = v;
      m_task[0] = v;
   endtask

   function automatic logic [IW-1:0] pick_id();
      // mostly ids already in use so start and stop find their targets
      if (ids_used.size() != 0 && $urandom_range(99) < 80)
         return ids_used[$urandom_range(ids_used.size() - 1)];
      return IW'($urandom);
   endfunction

   // --------------------------------------------------------------------
   // result checker
   // --------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer");
         end else begin
            sched_result_type e;
            e = expected_q.pop_front();
            if (e.status !== rsp_status || e.run_id !== rsp_running_task_id ||
                e.switched !== rsp_switched) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st=%0d id=%0d sw=%0d got st=%0d id=%0d sw=%0d",
                           e.status, e.run_id, e.switched, rsp_status,
                           rsp_running_task_id, rsp_switched);
            end
         end
      end
   end

   // receiver readiness, with a counted hold-off
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off  <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= rsp_noidle || ($urandom_range(99) >= 28);
   end

   // --------------------------------------------------------------------
   // tests
   // --------------------------------------------------------------------
   task automatic test_directed();
      send_cmd(tgpts_pkg::CMD_SCHED, '0, '0);       // idle with both groups empty
      send_cmd(tgpts_pkg::CMD_STOP, 10'd0, '0);     // idle slot never stopped
      send_cmd(tgpts_pkg::CMD_START, 10'h3ff, '0);  // nothing waiting
      send_cmd(tgpts_pkg::CMD_ADD, 10'h3ff, 2'd3);
      send_cmd(tgpts_pkg::CMD_ADD, 10'd0, 2'd0);
      send_cmd(tgpts_pkg::CMD_ADD, 10'd5, 2'd1);
      send_cmd(tgpts_pkg::CMD_ADD, 10'd5, 2'd2);    // duplicate id
      send_cmd(tgpts_pkg::CMD_SCHED, '0, '0);
      send_cmd(tgpts_pkg::CMD_SCHED, '0, '0);
      send_cmd(tgpts_pkg::CMD_STOP, 10'd0, '0);     // queued task stopped
      send_cmd(tgpts_pkg::CMD_STOP, 10'd0, '0);     // stop while already waiting
      send_cmd(tgpts_pkg::CMD_START, 10'd0, '0);    // stopped then started
      send_cmd(tgpts_pkg::CMD_SCHED, '0, '0);
      send_cmd(tgpts_pkg::CMD_STOP, 10'd5, '0);
      send_cmd(tgpts_pkg::CMD_STOP, 10'd5, '0);
      send_cmd(tgpts_pkg::CMD_START, 10'd5, '0);    // newest waiting duplicate
      send_cmd(tgpts_pkg::CMD_SCHED, '0, '0);
      send_cmd(tgpts_pkg::CMD_SCHED, '0, '0);
      send_cmd(tgpts_pkg::CMD_SCHED, '0, '0);
      send_cmd(tgpts_pkg::CMD_SCHED, '0, '0);
   endtask

   task automatic test_random(int n);
      logic [CW-1:0] c;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0, 1:    c = tgpts_pkg::CMD_ADD;
            2, 3, 4: c = tgpts_pkg::CMD_SCHED;
            5, 6:    c = tgpts_pkg::CMD_START;
            default: c = tgpts_pkg::CMD_STOP;
         endcase
         send_cmd(c, pick_id(), KW'($urandom));
      end
   endtask

   task automatic test_pool_exhaust();
      // fill every slot, then add must report no free slot
      for (int i = 0; i < NS + 2; i++)
         send_cmd(tgpts_pkg::CMD_ADD, IW'($urandom), KW'($urandom));
      send_cmd(tgpts_pkg::CMD_SCHED, '0, '0);
   endtask

   task automatic test_backpressure();
      hold_off = 300;
      req_noidle = 1;
      for (int i = 0; i < 12; i++) send_cmd(tgpts_pkg::CMD_SCHED, '0, '0);
      req_noidle = 0;
      drain();                 // sender pauses until all results are in
   endtask

   initial begin
      sched_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_idle_id(10'h3ff);
      test_random(500);
      write_idle_id(10'd0);
      rsp_noidle = 1; req_noidle = 1;
      test_random(300);
      rsp_noidle = 0; req_noidle = 0;
      write_idle_id(10'h2a5);
      test_random(400);
      test_pool_exhaust();
      test_backpressure();
      test_random(700);
      drain();
      if (mismatches == 0 && expected_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
